FILE: hw/rtl/rgb_to_lab_pixel_converter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sRGB to CIELAB converter
// Clocked concurrent assertion forms used by the port checker file.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_LAB_PIXEL_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_LAB_PIXEL_CONVERTER_UNIT_ASSERT_SVH

// checked only outside reset
`define R2L_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked in every cycle, reset included
`define R2L_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/r2l_pkg.sv
// ----------------------------------------------------------------------------
// r2l_pkg
// Beat types, conversion constants and the elaboration-time sRGB gamma curve.
// ----------------------------------------------------------------------------
package r2l_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pix_t;

  typedef struct packed {
    logic [7:0] lightness;
    logic [7:0] green_red_axis;
    logic [7:0] blue_yellow_axis;
  } lab_pix_t;

  // sRGB to XYZ matrix and D65 white, scaled by 1e6
  localparam int unsigned MAT_E6 [3][3] = '{
    '{412453, 357580, 180423},
    '{212671, 715160, 72169},
    '{19334, 119193, 950227}
  };
  localparam int unsigned WHITE_E6 [3] = '{950456, 1000000, 1088754};

  localparam int unsigned COEF_W     = 20;
  localparam int unsigned DIV_STAGES = 4;

  function automatic longint unsigned pow5_q30(longint unsigned y);
    longint unsigned p;
    p = y;
    for (int i = 0; i < 4; i++) begin
      p = (p * y) >> 30;
    end
    return p;
  endfunction

  // Linearized sRGB channel in Q(frac), used only to fill the gamma table
  function automatic longint unsigned srgb_lin(int unsigned c, int unsigned frac);
    longint unsigned cl, num, t, u, lo, cand, lin, res;
    cl = longint'(c);
    if (cl * 100000 <= 64'd1031475) begin
      num = (cl << frac) * 100;
      res = (num + 164730) / 329460;
    end else begin
      t  = (((cl * 1000 + 14025) << 30) + 134512) / 269025;
      u  = (t * t + (64'd1 << 29)) >> 30;
      lo = 0;
      // largest root with pow5 not above u, one bit at a time
      for (int i = 30; i >= 0; i--) begin
        cand = lo | (64'd1 << i);
        if (pow5_q30(cand) <= u) lo = cand;
      end
      lin = (u * lo + (64'd1 << 29)) >> 30;
      res = (lin + (64'd1 << (29 - frac))) >> (30 - frac);
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/r2l_xyz.sv
// ----------------------------------------------------------------------------
// r2l_xyz
// Gamma table lookup and 3x3 matrix; gives XYZ numerators ready for rounding
// division by the reference white. Three register stages.
// ----------------------------------------------------------------------------
module r2l_xyz import r2l_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int LW = FRAC_BITS + 1,
  localparam int NW = FRAC_BITS + 21
) (
  input  logic          clk,
  input  logic          en,
  input  rgb_pix_t      pix,
  output logic [NW-1:0] num [3]
);

  logic [LW-1:0] lut [256];
  logic [LW-1:0] lin_r [3];
  logic [LW-1:0] lin_nxt [3];
  logic [NW-1:0] prod_r [3][3];
  logic [NW-1:0] num_r [3];

  for (genvar g = 0; g < 256; g++) begin : g_lut
    localparam logic [LW-1:0] LinVal = LW'(srgb_lin(g, FRAC_BITS));
    assign lut[g] = LinVal;
  end

  assign lin_nxt[0] = lut[pix.red];
  assign lin_nxt[1] = lut[pix.green];
  assign lin_nxt[2] = lut[pix.blue];

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r <= lin_nxt;
    end
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[gi][gj] <= NW'(lin_r[gj]) * NW'(MAT_E6[gi][gj]);
        end
      end
    end

    // add half the white value so the later floor division rounds
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[gi] <= prod_r[gi][0] + prod_r[gi][1] + prod_r[gi][2]
                   + NW'(WHITE_E6[gi] / 2);
      end
    end
  end

  assign num = num_r;

endmodule

FILE: hw/rtl/r2l_cdiv.sv
// ----------------------------------------------------------------------------
// r2l_cdiv
// Floor division by a constant: reciprocal multiply in two halves, then one
// compare-and-correct step. Four register stages.
// ----------------------------------------------------------------------------
module r2l_cdiv #(
  parameter int              NW  = 37,
  parameter longint unsigned DIV = 1160,
  parameter int              QW  = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  output logic [QW-1:0] quo
);

  localparam longint unsigned Recip = (64'd1 << NW) / DIV;
  localparam int MW = $clog2(Recip + 1);
  localparam int DW = $clog2(DIV + 1);
  localparam int LO = NW / 2;
  localparam int HI = NW - LO;
  localparam int SW = NW + MW;

  logic [LO+MW-1:0] plo_r;
  logic [HI+MW-1:0] phi_r;
  logic [NW-1:0]    n1_r, n2_r, n3_r;
  logic [SW-1:0]    sum;
  logic [MW-1:0]    q0_r, q1_r;
  logic [MW+DW-1:0] prod_r;
  logic [NW-1:0]    rem;
  logic [MW:0]      qinc;
  logic [QW-1:0]    quo_r;

  assign sum  = (SW'(phi_r) << LO) + SW'(plo_r);
  assign rem  = n3_r - NW'(prod_r);
  assign qinc = (MW+1)'(q1_r) + (MW+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r  <= (LO+MW)'(num[LO-1:0]) * (LO+MW)'(Recip);
      phi_r  <= (HI+MW)'(num[NW-1:LO]) * (HI+MW)'(Recip);
      n1_r   <= num;
      q0_r   <= MW'(sum >> NW);
      n2_r   <= n1_r;
      prod_r <= (MW+DW)'(q0_r) * (MW+DW)'(DIV);
      q1_r   <= q0_r;
      n3_r   <= n2_r;
      // estimate is low by at most one
      quo_r  <= (rem >= NW'(DIV)) ? QW'(qinc) : QW'(q1_r);
    end
  end

  assign quo = quo_r;

endmodule

FILE: hw/rtl/r2l_cbrt.sv
// ----------------------------------------------------------------------------
// r2l_cbrt
// Fixed-point cube root, one root bit per two pipeline stages: square the
// candidate, then cube it and compare. Side data travels alongside.
// ----------------------------------------------------------------------------
module r2l_cbrt #(
  parameter int FRAC_BITS = 16,
  parameter int PW = 18,
  localparam int VW = FRAC_BITS + 2,
  localparam int YW = FRAC_BITS + 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] val,
  input  logic [PW-1:0] pass_i,
  output logic [YW-1:0] root,
  output logic [PW-1:0] pass_o
);

  localparam int SQW = YW + 1;
  localparam int CFW = SQW + YW;

  logic [YW-1:0] y_s [YW+1];
  logic [VW-1:0] v_s [YW+1];
  logic [PW-1:0] p_s [YW+1];

  assign y_s[0] = '0;
  assign v_s[0] = val;
  assign p_s[0] = pass_i;

  for (genvar gi = 0; gi < YW; gi++) begin : g_bit
    localparam int BitPos = YW - 1 - gi;

    logic [YW-1:0]   cand_nxt;
    logic [2*YW-1:0] sq_full;
    logic [YW-1:0]   cand_r, ya_r, yb_r;
    logic [SQW-1:0]  sq_r;
    logic [VW-1:0]   va_r, vb_r;
    logic [PW-1:0]   pa_r, pb_r;
    logic [CFW-1:0]  cube_full;
    logic            fits;

    assign cand_nxt  = y_s[gi] | (YW'(1) << BitPos);
    assign sq_full   = (2*YW)'(cand_nxt) * (2*YW)'(cand_nxt);
    assign cube_full = CFW'(sq_r) * CFW'(cand_r);
    assign fits      = (cube_full >> FRAC_BITS) <= CFW'(va_r);

    always_ff @(posedge clk) begin
      if (en) begin
        cand_r <= cand_nxt;
        ya_r   <= y_s[gi];
        sq_r   <= SQW'(sq_full >> FRAC_BITS);
        va_r   <= v_s[gi];
        pa_r   <= p_s[gi];
        // keep the bit only if the cube stays at or below the operand
        yb_r   <= fits ? cand_r : ya_r;
        vb_r   <= va_r;
        pb_r   <= pa_r;
      end
    end

    assign y_s[gi+1] = yb_r;
    assign v_s[gi+1] = vb_r;
    assign p_s[gi+1] = pb_r;
  end

  assign root   = y_s[YW];
  assign pass_o = p_s[YW];

endmodule

FILE: hw/rtl/r2l_cie.sv
// ----------------------------------------------------------------------------
// r2l_cie
// CIE f() for one channel: epsilon test, linear segment through a constant
// divider, cube root segment, and the final select.
// ----------------------------------------------------------------------------
module r2l_cie import r2l_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int VW = FRAC_BITS + 2,
  localparam int FW = FRAC_BITS + 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] val,
  output logic [FW-1:0] fval
);

  localparam int CW  = VW + 20;
  localparam int LNW = FRAC_BITS + 17;

  logic [CW-1:0]  eps_prod;
  logic           big_r;
  logic [VW-1:0]  v0_r;
  logic [LNW-1:0] lnum_r;
  logic [FW-1:0]  linq;
  logic [VW-1:0]  dv_r [DIV_STAGES];
  logic           db_r [DIV_STAGES];
  logic [FW-1:0]  root;
  logic [FW:0]    side;

  assign eps_prod = CW'(val) * CW'(1000000);

  always_ff @(posedge clk) begin
    if (en) begin
      big_r  <= eps_prod > (CW'(8856) << FRAC_BITS);
      v0_r   <= val;
      lnum_r <= LNW'(val) * LNW'(9033) + (LNW'(160) << FRAC_BITS) + LNW'(580);
    end
  end

  r2l_cdiv #(
    .NW (LNW),
    .DIV(1160),
    .QW (FW)
  ) u_lin_div (
    .clk(clk),
    .en (en),
    .num(lnum_r),
    .quo(linq)
  );

  // match the divider latency
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= v0_r;
      db_r[0] <= big_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_r[k] <= dv_r[k-1];
        db_r[k] <= db_r[k-1];
      end
    end
  end

  r2l_cbrt #(
    .FRAC_BITS(FRAC_BITS),
    .PW       (FW + 1)
  ) u_cbrt (
    .clk   (clk),
    .en    (en),
    .val   (dv_r[DIV_STAGES-1]),
    .pass_i({db_r[DIV_STAGES-1], linq}),
    .root  (root),
    .pass_o(side)
  );

  assign fval = side[FW] ? root : side[FW-1:0];

endmodule

FILE: hw/rtl/r2l_outfmt.sv
// ----------------------------------------------------------------------------
// r2l_outfmt
// Forms L*, a*, b* from the f() values, then rounds and saturates to 8 bits.
// Two register stages.
// ----------------------------------------------------------------------------
module r2l_outfmt import r2l_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int FW = FRAC_BITS + 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [FW-1:0] fx,
  input  logic [FW-1:0] fy,
  input  logic [FW-1:0] fz,
  output lab_pix_t      lab
);

  localparam int LSW = FRAC_BITS + 18;
  localparam int LXW = LSW - 1 - (FRAC_BITS + 2);
  localparam int AW  = FRAC_BITS + 12;
  localparam int ATW = AW - 1 - FRAC_BITS;

  logic [LSW-1:0] lsum;
  logic [AW-1:0]  asum, bsum;
  logic           lneg_r, aneg_r, bneg_r;
  logic [LXW-1:0] lx_r;
  logic [ATW-1:0] at_r, bt_r;
  logic [31:0]    lscaled;
  lab_pix_t       lab_r;

  // (116*fy - 16) * 255 + 50, all in Q(F); 116*255 = 29580
  assign lsum = LSW'(fy) * LSW'(29580) + (LSW'(50) << FRAC_BITS)
              - (LSW'(4080) << FRAC_BITS);
  assign asum = AW'(fx) * AW'(500) - AW'(fy) * AW'(500)
              + (AW'(128) << FRAC_BITS) + (AW'(1) << (FRAC_BITS - 1));
  assign bsum = AW'(fy) * AW'(200) - AW'(fz) * AW'(200)
              + (AW'(128) << FRAC_BITS) + (AW'(1) << (FRAC_BITS - 1));

  // divide by 25 through a reciprocal; exact below the saturation point
  assign lscaled = (32'(lx_r) * 32'(41944)) >> 20;

  always_ff @(posedge clk) begin
    if (en) begin
      lneg_r <= lsum[LSW-1];
      lx_r   <= lsum[LSW-2:FRAC_BITS+2];
      aneg_r <= asum[AW-1];
      at_r   <= asum[AW-2:FRAC_BITS];
      bneg_r <= bsum[AW-1];
      bt_r   <= bsum[AW-2:FRAC_BITS];

      if (lneg_r) lab_r.lightness <= 8'd0;
      else if (lx_r >= LXW'(6400)) lab_r.lightness <= 8'd255;
      else lab_r.lightness <= lscaled[7:0];

      if (aneg_r) lab_r.green_red_axis <= 8'd0;
      else if (at_r > ATW'(255)) lab_r.green_red_axis <= 8'd255;
      else lab_r.green_red_axis <= at_r[7:0];

      if (bneg_r) lab_r.blue_yellow_axis <= 8'd0;
      else if (bt_r > ATW'(255)) lab_r.blue_yellow_axis <= 8'd255;
      else lab_r.blue_yellow_axis <= bt_r[7:0];
    end
  end

  assign lab = lab_r;

endmodule

FILE: hw/rtl/rgb_to_lab_pixel_converter_unit.sv
// Throughput: one pixel per clock while the output buffer has room; the cube-root
// pipeline, two stages per root bit, sets the depth, and every stage takes a new
// pixel each cycle unless the full buffer stalls the pipeline.
// A two-entry output buffer keeps input flowing while a result waits.
// Reset (rst_n low, synchronous) clears the valid bits and the output buffer.
// ----------------------------------------------------------------------------
// rgb_to_lab_pixel_converter_unit
// 8-bit sRGB to 8-bit CIELAB pixel converter, fully pipelined.
// ----------------------------------------------------------------------------
module rgb_to_lab_pixel_converter_unit import r2l_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rgb_pix_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lab_pix_t out_data
);

  localparam int YW    = FRAC_BITS + 1;
  localparam int NW    = FRAC_BITS + 21;
  localparam int VW    = FRAC_BITS + 2;
  localparam int FW    = FRAC_BITS + 1;
  localparam int DEPTH = 3 + DIV_STAGES + 1 + DIV_STAGES + 2 * YW + 2;

  logic             en;
  logic [DEPTH-1:0] vld_r;
  logic [NW-1:0]    num [3];
  logic [VW-1:0]    xyz [3];
  logic [FW-1:0]    fv [3];
  lab_pix_t         lab;

  lab_pix_t         buf_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  // advance the whole pipeline while the output buffer has room
  assign en       = cnt_r != 2'd2;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  r2l_xyz #(.FRAC_BITS(FRAC_BITS)) u_xyz (
    .clk(clk),
    .en (en),
    .pix(in_data),
    .num(num)
  );

  for (genvar gi = 0; gi < 3; gi++) begin : g_lane
    r2l_cdiv #(
      .NW (NW),
      .DIV(longint'(WHITE_E6[gi])),
      .QW (VW)
    ) u_white_div (
      .clk(clk),
      .en (en),
      .num(num[gi]),
      .quo(xyz[gi])
    );

    r2l_cie #(.FRAC_BITS(FRAC_BITS)) u_cie (
      .clk (clk),
      .en  (en),
      .val (xyz[gi]),
      .fval(fv[gi])
    );
  end

  r2l_outfmt #(.FRAC_BITS(FRAC_BITS)) u_outfmt (
    .clk(clk),
    .en (en),
    .fx (fv[0]),
    .fy (fv[1]),
    .fz (fv[2]),
    .lab(lab)
  );

  assign push    = en && vld_r[DEPTH-1];
  assign pop     = out_valid && out_ready;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= lab;
    end
  end

  assign out_valid = cnt_r != 2'd0;
  assign out_data  = buf_r[rd_ptr_r];

endmodule

FILE: hw/rtl/r2l_port_checker.sv
// ----------------------------------------------------------------------------
// r2l_port_checker
// Port-level checks of the converter: reset state, beat hold, back-pressure.
// ----------------------------------------------------------------------------
`include "rgb_to_lab_pixel_converter_unit_assert.svh"

module r2l_port_checker import r2l_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input rgb_pix_t in_data,
  input logic     out_valid,
  input logic     out_ready,
  input lab_pix_t out_data
);

  logic in_stall;
  logic out_stall;

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;

  `R2L_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")
  `R2L_ASSERT_RST(a_reset_ready, !rst_n |=> in_ready, "input not ready right after reset")
  `R2L_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_data), "held beat changed")
  `R2L_ASSERT(a_in_hold, in_stall |=> in_valid && $stable(in_data), "input beat dropped")
  `R2L_ASSERT(a_stall_needs_result, !in_ready |-> out_valid, "stall with nothing waiting")

endmodule

bind rgb_to_lab_pixel_converter_unit r2l_port_checker u_port_checker (.*);

FILE: tb/sv/rgb_to_lab_pixel_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_lab_pixel_converter_unit_tb
// Streams sRGB pixels through the converter with random gaps and stalls on
// both sides, directed table first, then random pixels. Every output beat is
// checked field by field against the table or a fixed-point CIELAB predictor.
// ----------------------------------------------------------------------------
module rgb_to_lab_pixel_converter_unit_tb import r2l_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB        = 16;
  localparam int N_RANDOM  = 1650;
  localparam int MAX_CYC   = 400000;
  localparam int DRAIN_CYC = 2 * FB + 40;

  typedef struct packed {
    logic     has_exp;
    rgb_pix_t pix;
    lab_pix_t lab;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rgb_pix_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lab_pix_t out_data;

  lab_pix_t lab_expected_q[$];
  int       errors = 0;
  int       cycles = 0;
  bit       calm = 1'b0;
  bit       stim_done = 1'b0;

  rgb_to_lab_pixel_converter_unit #(.FRAC_BITS(FB)) uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- predictor ------------------------------------------------------------
  function automatic longint unsigned q30_pow5(longint unsigned y);
    longint unsigned p;
    p = y;
    for (int i = 0; i < 4; i++) p = (p * y) >> 30;
    return p;
  endfunction

  function automatic longint linearize(logic [7:0] ch);
    longint unsigned c, t, u, lo, hi, mid, lin;
    c = ch;
    if (c * 100000 <= 4045 * 255) return longint'(((c << FB) * 100 + 164730) / 329460);
    t  = (((c * 1000 + 14025) << 30) + 134512) / 269025;
    u  = (t * t + (64'd1 << 29)) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (q30_pow5(mid) <= u) lo = mid;
      else hi = mid - 1;
    end
    lin = (u * lo + (64'd1 << 29)) >> 30;
    return longint'((lin + (64'd1 << (29 - FB))) >> (30 - FB));
  endfunction

  function automatic longint lab_f(longint v);
    longint unsigned lo, hi, mid, cube;
    if (v * 1000000 > (longint'(8856) << FB)) begin
      lo = 0;
      hi = 64'd1 << (FB + 1);
      while (lo < hi) begin
        mid  = (lo + hi + 1) >> 1;
        cube = (((mid * mid) >> FB) * mid) >> FB;
        if (cube <= longint'(v)) lo = mid;
        else hi = mid - 1;
      end
      return longint'(lo);
    end
    return (9033 * v + (longint'(160) << FB) + 580) / 1160;
  endfunction

  function automatic logic [7:0] round_clamp(longint q);
    longint r;
    r = q + (longint'(1) << (FB - 1));
    if (r < 0) return 8'd0;
    r = r >>> FB;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic lab_pix_t rgb_to_lab(rgb_pix_t p);
    longint   lin[3];
    longint   fv[3];
    longint   acc, lnum;
    lab_pix_t res;
    lin[0] = linearize(p.red);
    lin[1] = linearize(p.green);
    lin[2] = linearize(p.blue);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += longint'(MAT_E6[i][j]) * lin[j];
      fv[i] = lab_f((acc + longint'(WHITE_E6[i]) / 2) / longint'(WHITE_E6[i]));
    end
    lnum = (116 * fv[1] - (longint'(16) << FB)) * 255 + (longint'(50) << FB);
    if (lnum < 0) res.lightness = 8'd0;
    else begin
      lnum = lnum / (longint'(100) << FB);
      res.lightness = (lnum > 255) ? 8'd255 : lnum[7:0];
    end
    res.green_red_axis   = round_clamp(500 * (fv[0] - fv[1]) + (longint'(128) << FB));
    res.blue_yellow_axis = round_clamp(200 * (fv[1] - fv[2]) + (longint'(128) << FB));
    return res;
  endfunction

  // ---- directed table -------------------------------------------------------
  // Black and white read off at a glance; the rest go to the predictor.
  stim_row_t directed_rows[] = '{
    '{1'b1, '{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd128, 8'd128}},
    '{1'b1, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd128, 8'd128}},
    '{1'b0, '{8'd255, 8'd0, 8'd0}, '0},
    '{1'b0, '{8'd0, 8'd255, 8'd0}, '0},
    '{1'b0, '{8'd0, 8'd0, 8'd255}, '0},
    '{1'b0, '{8'd255, 8'd255, 8'd0}, '0},
    '{1'b0, '{8'd0, 8'd255, 8'd255}, '0},
    '{1'b0, '{8'd255, 8'd0, 8'd255}, '0},
    '{1'b0, '{8'd10, 8'd10, 8'd10}, '0},
    '{1'b0, '{8'd11, 8'd11, 8'd11}, '0},
    '{1'b0, '{8'd1, 8'd1, 8'd1}, '0},
    '{1'b0, '{8'd2, 8'd3, 8'd4}, '0},
    '{1'b0, '{8'd128, 8'd128, 8'd128}, '0},
    '{1'b0, '{8'd170, 8'd85, 8'd170}, '0},
    '{1'b0, '{8'd85, 8'd170, 8'd85}, '0},
    '{1'b0, '{8'd254, 8'd1, 8'd0}, '0},
    '{1'b0, '{8'd0, 8'd1, 8'd254}, '0},
    '{1'b0, '{8'd20, 8'd0, 8'd0}, '0},
    '{1'b0, '{8'd0, 8'd0, 8'd20}, '0}
  };

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 24);
  endfunction

  // ---- source ---------------------------------------------------------------
  task automatic send_pixel(rgb_pix_t p, lab_pix_t want);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lab_expected_q = {lab_expected_q, want};
    @(negedge clk);
  endtask

  initial begin
    rgb_pix_t p;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].has_exp)
        send_pixel(directed_rows[k].pix, directed_rows[k].lab);
      else
        send_pixel(directed_rows[k].pix, rgb_to_lab(directed_rows[k].pix));
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 900);
      case ($urandom_range(3))
        0: p = {8'($urandom_range(20)), 8'($urandom_range(20)), 8'($urandom_range(20))};
        1: p = {8'($urandom_range(255, 235)), 8'($urandom), 8'($urandom_range(20))};
        default: p = 24'($urandom);
      endcase
      send_pixel(p, rgb_to_lab(p));
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    stim_done = 1'b1;
  end

  // ---- sink -----------------------------------------------------------------
  always @(negedge clk) out_ready <= !idle_now();

  always @(posedge clk) begin
    lab_pix_t e;
    if (rst_n && out_valid && out_ready) begin
      if (lab_expected_q.size() == 0) begin
        $error("output beat with no pixel pending: %h", out_data);
        errors++;
      end else begin
        e = lab_expected_q.pop_front();
        if (out_data.lightness !== e.lightness) begin
          $error("lightness exp %0d got %0d", e.lightness, out_data.lightness);
          errors++;
        end
        if (out_data.green_red_axis !== e.green_red_axis) begin
          $error("green_red_axis exp %0d got %0d", e.green_red_axis, out_data.green_red_axis);
          errors++;
        end
        if (out_data.blue_yellow_axis !== e.blue_yellow_axis) begin
          $error("blue_yellow_axis exp %0d got %0d", e.blue_yellow_axis,
                 out_data.blue_yellow_axis);
          errors++;
        end
      end
    end
  end

  // ---- end of run -----------------------------------------------------------
  initial begin
    wait (stim_done);
    while (lab_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYC) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/r2l_pkg.sv
hw/rtl/r2l_xyz.sv
hw/rtl/r2l_cdiv.sv
hw/rtl/r2l_cbrt.sv
hw/rtl/r2l_cie.sv
hw/rtl/r2l_outfmt.sv
hw/rtl/rgb_to_lab_pixel_converter_unit.sv
hw/rtl/r2l_port_checker.sv
tb/sv/rgb_to_lab_pixel_converter_unit_tb.sv
